/* design/lkvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Beat layouts of both channels, the control group that the top level hands
// to every cell, command codes and the reset value of the capacity register.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Width of the capacity register.
    localparam int CFG_W = 5;

    // Capacity register value after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Value returned by a get that misses.
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef logic signed [31:0] t_key;
    typedef logic signed [31:0] t_value;

    // One request beat.
    typedef struct packed {
        logic   command;
        t_key   key;
        t_value value;
    } t_in_beat;

    // One response beat.
    typedef struct packed {
        logic   found;
        t_value read_value;
    } t_out_beat;

    // Control group broadcast to the row of cells.
    typedef struct packed {
        logic update_en;
        logic insert;
        logic hit_any;
        t_key key;
    } t_cell_ctrl;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

endpackage

/* design/lkvc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell: one slot of the recency-ordered chain
// Holds one key/value pair, compares its key with the request key and, when
// told to shift, takes the pair of the neighbour nearer the front.
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                 i_clk,
    input  lkvc_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [IDX_W-1:0]     i_hit_idx,
    input  lkvc_pkg::t_key       i_prev_key,
    input  lkvc_pkg::t_value     i_prev_value,
    output lkvc_pkg::t_key       o_key,
    output lkvc_pkg::t_value     o_value,
    output logic                 o_match,
    output lkvc_pkg::t_value     o_hit_value
);

    lkvc_pkg::t_key   r_key;
    lkvc_pkg::t_value r_value;
    logic             w_valid;
    logic             w_is_hit;
    logic             w_load;

    // The valid slots always form a prefix of the chain.
    assign w_valid = (i_count > CNT_W'(IDX));

    // Key comparison for the lookup cycle.
    assign o_match = w_valid && (r_key == i_ctrl.key);

    // This cell holds the entry found by the lookup.
    assign w_is_hit    = i_ctrl.hit_any && (i_hit_idx == IDX_W'(IDX));
    assign o_hit_value = w_is_hit ? r_value : '0;

    // Shift on an insertion, or when the hit lies at or behind this cell.
    assign w_load = i_ctrl.update_en &&
                    (i_ctrl.insert || (i_ctrl.hit_any && (i_hit_idx >= IDX_W'(IDX))));

    // Slot storage; contents only matter while the slot is valid.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

/* design/lru_key_value_cache_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative LRU key/value cache
// A row of cells kept in recency order with the most recent entry in front.
// ----------------------------------------------------------------------------
// Each request passes a lookup and an update state: in the lookup state every
// cell compares its key with the request key and the hit position is
// registered; in the update state the chain shifts one place towards the back
// up to the hit position (or along its whole length for an insertion) while
// the front cell takes the request's entry. A new request beat is taken in the
// update state, so the next lookup follows straight on; the shift waits only
// when a get result still sits unclaimed in the output register. A get
// response appears in the cycle after its shift; a set gives no response.
// Capacity writes are clamped to the range one to MAX_ENTRIES.
module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lkvc_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lkvc_pkg::t_out_beat            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;

    lkvc_pkg::t_state      r_state;
    lkvc_pkg::t_state      n_state;
    lkvc_pkg::t_in_beat    r_in;
    logic [lkvc_pkg::CFG_W-1:0] r_cap_cfg;
    logic [CNT_W-1:0]      r_count;
    logic                  r_hit_any;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_out_valid;
    lkvc_pkg::t_out_beat   r_out_data;

    logic                  w_ready;
    logic                  w_update;
    logic                  w_accept;
    logic                  w_is_set;
    logic                  w_insert;
    logic [CNT_W-1:0]      w_cap;
    logic [CW-1:0]         w_cfg_ext;
    logic [IDX_W-1:0]      w_hit_idx_enc;
    lkvc_pkg::t_value      w_hit_value;
    lkvc_pkg::t_value      w_front_value;
    lkvc_pkg::t_cell_ctrl  w_ctrl;

    logic [MAX_ENTRIES-1:0] w_match;
    lkvc_pkg::t_key        w_key     [MAX_ENTRIES];
    lkvc_pkg::t_value      w_value   [MAX_ENTRIES];
    lkvc_pkg::t_value      w_hit_val [MAX_ENTRIES];

    assign w_is_set = (r_in.command == lkvc_pkg::CMD_SET);
    assign w_insert = w_is_set && !r_hit_any;
    assign w_accept = i_in_valid && w_ready;

    // Effective capacity: the register clamped to one .. MAX_ENTRIES.
    assign w_cfg_ext = CW'(r_cap_cfg);
    always_comb begin
        if (r_cap_cfg == '0) begin
            w_cap = CNT_W'(1);
        end else if (w_cfg_ext > CW'(MAX_ENTRIES)) begin
            w_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            w_cap = CNT_W'(w_cfg_ext);
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, input handshake and shift enable.
    always_comb begin
        n_state  = r_state;
        w_ready  = 1'b0;
        w_update = 1'b0;
        case (r_state)
            lkvc_pkg::ST_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = lkvc_pkg::ST_LOOKUP;
                end
            end
            lkvc_pkg::ST_LOOKUP: begin
                n_state = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE: begin
                if (w_is_set || !r_out_valid || i_out_ready) begin
                    w_update = 1'b1;
                    w_ready  = 1'b1;
                    n_state  = i_in_valid ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap_cfg <= i_cfg_wdata;
        end
    end

    // Encode the hit position; valid keys are unique, so at most one matches.
    always_comb begin
        w_hit_idx_enc = '0;
        w_hit_value   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_idx_enc = w_hit_idx_enc | IDX_W'(i);
            end
            w_hit_value = w_hit_value | w_hit_val[i];
        end
    end

    // Lookup result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_any <= 1'b0;
            r_hit_idx <= '0;
        end else if (r_state == lkvc_pkg::ST_LOOKUP) begin
            r_hit_any <= |w_match;
            r_hit_idx <= w_hit_idx_enc;
        end
    end

    // Entry count; an insertion into a full store drops the tail first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_update && w_insert) begin
            if (r_count >= w_cap) begin
                r_count <= w_cap;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // The front cell takes the request key with the new or the found value.
    assign w_front_value = w_is_set ? r_in.value : w_hit_value;

    assign w_ctrl.update_en = w_update;
    assign w_ctrl.insert    = w_insert;
    assign w_ctrl.hit_any   = r_hit_any;
    assign w_ctrl.key       = r_in.key;

    // The chain of cells.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkvc_pkg::t_key   w_prev_key;
        lkvc_pkg::t_value w_prev_value;

        if (g == 0) begin : g_front
            assign w_prev_key   = r_in.key;
            assign w_prev_value = w_front_value;
        end else begin : g_rest
            assign w_prev_key   = w_key[g-1];
            assign w_prev_value = w_value[g-1];
        end

        lkvc_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_hit_idx    (r_hit_idx),
            .i_prev_key   (w_prev_key),
            .i_prev_value (w_prev_value),
            .o_key        (w_key[g]),
            .o_value      (w_value[g]),
            .o_match      (w_match[g]),
            .o_hit_value  (w_hit_val[g])
        );
    end

    // Output register: a get loads it in its shift cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update && !w_is_set) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update && !w_is_set) begin
            r_out_data.found      <= r_hit_any;
            r_out_data.read_value <= r_hit_any ? w_hit_value : lkvc_pkg::MISS_VALUE;
        end
    end

    assign o_in_ready  = w_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The entry count never passes the size of the chain.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond chain length");

    // Valid keys are unique, so a lookup finds at most one cell.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkvc_pkg::ST_LOOKUP) |-> $onehot0(w_match))
        else $error("several cells match one key");

    // An insertion leaves the count no larger than the effective capacity.
    a_insert_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_update && w_insert) |=> (r_count <= $past(w_cap)) && (r_count != '0))
        else $error("insertion left count outside capacity");

    // A set produces no response beat.
    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_update && w_is_set) |=> (r_out_valid == $past(r_out_valid && !i_out_ready)))
        else $error("set produced a response");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the LRU key/value cache
// A short table of directed requests and capacity writes, then random phases
// at several capacities. Every accepted request is run through a recency-list
// model held here, and each response beat is compared with the oldest lookup
// still waiting for its answer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LRU_DEPTH  = 16;
    localparam int SETTLE_CYC = 8;
    localparam int N_PHASES   = 10;
    localparam int PHASE_REQS = 115;

    localparam lkvc_pkg::t_out_beat MISS_BEAT = '{1'b0, lkvc_pkg::MISS_VALUE};
    localparam lkvc_pkg::t_out_beat NO_WANT   = '0;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: a request, or a capacity write.
    typedef struct {
        t_row_kind                  kind;
        logic [lkvc_pkg::CFG_W-1:0] cap;
        lkvc_pkg::t_in_beat         beat;
        bit                         typed;
        lkvc_pkg::t_out_beat        want;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    lkvc_pkg::t_in_beat         i_in_data;
    logic                       o_out_valid;
    logic                       i_out_ready;
    lkvc_pkg::t_out_beat        o_out_data;
    logic                       i_cfg_we;
    logic [lkvc_pkg::CFG_W-1:0] i_cfg_wdata;

    // Recency list kept by the testbench: slot 0 is the most recent entry.
    lkvc_pkg::t_key             lru_keys [LRU_DEPTH];
    lkvc_pkg::t_value           lru_vals [LRU_DEPTH];
    int                         lru_fill;
    logic [lkvc_pkg::CFG_W-1:0] cap_reg;

    // Lookup answers still owed by the block, oldest first.
    lkvc_pkg::t_out_beat pending_gets [$];
    lkvc_pkg::t_out_beat head_want;

    bit calm_phase;
    int err_count;
    int lookups_sent;
    int stores_sent;
    int hits_seen;
    int settings_count;

    lru_key_value_cache_top #(
        .MAX_ENTRIES(LRU_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Directed requests: empty store, extreme keys and values, updates, a
    // capacity of one, clamping at both ends, and a capacity cut below the fill.
    t_row dir_rows [0:30] = '{
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd0, 32'sd0}, 1'b1, MISS_BEAT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1,
            MISS_BEAT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0,
            NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sh7FFF_FFFF, 32'sd0}, 1'b1,
            '{1'b1, 32'sh8000_0000}},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b0,
            NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sh8000_0000, 32'sd0}, 1'b1,
            '{1'b1, 32'sh7FFF_FFFF}},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sh7FFF_FFFF, -32'sd1}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sh7FFF_FFFF, 32'sd0}, 1'b1,
            '{1'b1, -32'sd1}},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, -32'sd1, 32'sd0}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd0, -32'sd1}, 1'b1, MISS_BEAT},
        '{ROW_CFG, 5'd1, '0, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sh8000_0000, 32'sd0}, 1'b1,
            '{1'b1, 32'sh7FFF_FFFF}},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd5, 32'sd50}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, -32'sd1, 32'sd0}, 1'b1, MISS_BEAT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd5, 32'sd0}, 1'b1, '{1'b1, 32'sd50}},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd6, 32'sd60}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd5, 32'sd0}, 1'b1, MISS_BEAT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd6, 32'sd0}, 1'b1, '{1'b1, 32'sd60}},
        '{ROW_CFG, 5'd0, '0, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd7, 32'sd70}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd6, 32'sd0}, 1'b1, MISS_BEAT},
        '{ROW_CFG, 5'd31, '0, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd1, 32'sd10}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd2, 32'sd20}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd7, 32'sd0}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd1, 32'sd11}, 1'b0, NO_WANT},
        '{ROW_CFG, 5'd2, '0, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_SET, 32'sd3, 32'sd30}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd2, 32'sd0}, 1'b0, NO_WANT},
        '{ROW_REQ, 5'd0, '{lkvc_pkg::CMD_GET, 32'sd1, 32'sd0}, 1'b0, NO_WANT},
        '{ROW_CFG, 5'd16, '0, 1'b0, NO_WANT}
    };

    // Capacity settings of the random phases, clamped values among them.
    logic [lkvc_pkg::CFG_W-1:0] phase_caps [N_PHASES] = '{
        5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd5
    };

    // Number of entries the cache may hold for a given register value.
    function automatic int cap_limit(input logic [lkvc_pkg::CFG_W-1:0] reg_val);
        if (reg_val == 0) begin
            return 1;
        end
        if (reg_val > LRU_DEPTH) begin
            return LRU_DEPTH;
        end
        return int'(reg_val);
    endfunction

    // Applies one request to the recency list; a lookup also yields its answer.
    task automatic model_request(input lkvc_pkg::t_in_beat beat, output bit has_res,
                                 output lkvc_pkg::t_out_beat res);
        int               hit;
        int               lim;
        int               i;
        lkvc_pkg::t_value v;
        hit = -1;
        for (i = 0; i < lru_fill && hit < 0; i++) begin
            if (lru_keys[i] == beat.key) begin
                hit = i;
            end
        end
        has_res = (beat.command == lkvc_pkg::CMD_GET);
        res     = MISS_BEAT;
        if (hit >= 0) begin
            v = (beat.command == lkvc_pkg::CMD_SET) ? beat.value : lru_vals[hit];
            for (i = hit; i > 0; i--) begin
                lru_keys[i] = lru_keys[i-1];
                lru_vals[i] = lru_vals[i-1];
            end
            lru_keys[0] = beat.key;
            lru_vals[0] = v;
            res = '{1'b1, v};
        end else if (beat.command == lkvc_pkg::CMD_SET) begin
            // A new key first drops least recent entries down to one free place.
            lim = cap_limit(cap_reg);
            if (lru_fill >= lim) begin
                lru_fill = lim - 1;
            end
            for (i = lru_fill; i > 0; i--) begin
                lru_keys[i] = lru_keys[i-1];
                lru_vals[i] = lru_vals[i-1];
            end
            lru_keys[0] = beat.key;
            lru_vals[0] = beat.value;
            lru_fill++;
        end
    endtask

    // Offers one request beat after a gap, then records what it should return.
    task automatic offer_request(input lkvc_pkg::t_in_beat beat, input int gap,
                                 input bit typed, input lkvc_pkg::t_out_beat want);
        bit                  has_res;
        lkvc_pkg::t_out_beat predicted;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        model_request(beat, has_res, predicted);
        if (has_res) begin
            pending_gets.push_back(typed ? want : predicted);
            lookups_sent++;
        end else begin
            stores_sent++;
        end
    endtask

    // Stops sending and waits until every answer is in and the block is quiet.
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_gets.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] reg_val);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= reg_val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = reg_val;
        settings_count++;
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Response side: holds ready low for a random stall before each beat.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm_phase ? 0 : $urandom_range(0, 4);
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) begin
                @(posedge i_clk);
            end
        end
    end

    // Response checker: each accepted beat against the oldest owed answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_gets.size() == 0) begin
                err_count++;
                $display("%0t: response beat with nothing owed: found=%0b value=%0d",
                         $time, o_out_data.found, o_out_data.read_value);
            end else begin
                head_want = pending_gets.pop_front();
                if (o_out_data.found)
                    hits_seen++;
                if (o_out_data.found !== head_want.found) begin
                    err_count++;
                    $display("%0t: found mismatch: expected %0b, got %0b",
                             $time, head_want.found, o_out_data.found);
                end
                if (o_out_data.read_value !== head_want.read_value) begin
                    err_count++;
                    $display("%0t: read_value mismatch: expected %0d, got %0d",
                             $time, head_want.read_value, o_out_data.read_value);
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("%0t: run limit reached with %0d answers owed", $time,
                 pending_gets.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        lkvc_pkg::t_key     key_pool [20];
        lkvc_pkg::t_in_beat beat;
        int                 pool_n;
        int                 pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        calm_phase  = 1'b0;
        lru_fill    = 0;
        cap_reg     = lkvc_pkg::CAP_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_capacity(dir_rows[r].cap);
            end else begin
                offer_request(dir_rows[r].beat, $urandom_range(0, 4), dir_rows[r].typed,
                              dir_rows[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(phase_caps[ph]);
            calm_phase = ($urandom_range(0, 3) == 0);
            // A few keys more than fit, so that hits, misses and evictions mix.
            pool_n = cap_limit(cap_reg) + 3;
            for (int p = 0; p < pool_n; p++) begin
                key_pool[p] = $urandom;
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    beat.key = key_pool[$urandom_range(0, pool_n - 1)];
                end else if (pick < 82) begin
                    beat.key = pick[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                end else begin
                    beat.key = $urandom;
                end
                beat.command = ($urandom_range(0, 99) < 45) ? lkvc_pkg::CMD_GET
                                                             : lkvc_pkg::CMD_SET;
                beat.value   = $urandom;
                // Now and then let everything drain before going on.
                if ($urandom_range(0, 199) == 0) begin
                    settle_idle();
                end
                offer_request(beat, calm_phase ? 0 : $urandom_range(0, 4), 1'b0, NO_WANT);
            end
        end

        settle_idle();
        $display("Sent %0d lookups and %0d stores over %0d capacity settings;",
                 lookups_sent, stores_sent, settings_count);
        $display("%0d lookups hit, %0d mismatches.", hits_seen, err_count);
        if (err_count == 0 && pending_gets.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
